// ===== rtl/tmd_pkg.sv =====
// Shared types, register map, result codes and the Morse code table.
`default_nettype none

package tmd_pkg;

   // Result kinds reported on the response channel.
   typedef enum logic [2:0] {
      KIND_DOT     = 3'd0,
      KIND_DASH    = 3'd1,
      KIND_CHAR    = 3'd2,
      KIND_UNKNOWN = 3'd3,
      KIND_SPACE   = 3'd4
   } kind_type;

   // Register indexes on the configuration port (byte address is 4 * index).
   typedef enum logic [1:0] {
      REG_TOUCH_THRESHOLD = 2'd0,
      REG_DASH_TICKS      = 2'd1,
      REG_CHAR_GAP_TICKS  = 2'd2,
      REG_WORD_GAP_TICKS  = 2'd3
   } reg_index_type;

   localparam int          CSR_ADDR_BITS   = 4;
   localparam int          CSR_DATA_BITS   = 32;
   localparam int          CFG_BITS        = 16;
   localparam logic [15:0] THRESHOLD_RESET = 16'd20;
   localparam logic [15:0] DASH_RESET      = 16'd300;
   localparam logic [15:0] CHAR_GAP_RESET  = 16'd700;
   localparam logic [15:0] WORD_GAP_RESET  = 16'd1000;
   localparam logic [7:0]  ASCII_SPACE     = 8'h20;
   localparam logic [7:0]  ASCII_NONE      = 8'h00;

   // Depth of the queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;

   // Timing registers that the back part needs.
   typedef struct packed {
      logic [15:0] dash_ticks;
      logic [15:0] char_gap_ticks;
      logic [15:0] word_gap_ticks;
   } cfg_type;

   // Outcome of a table lookup.
   typedef struct packed {
      logic       hit;
      logic [7:0] code;
   } lookup_type;

   // Code table: element i of a symbol sits in bit i, a dash is a one.
   localparam int ROM_SIZE = 38;
   localparam logic [4:0] ROM_CODE [ROM_SIZE] = '{
      5'd2,  5'd1,  5'd5,  5'd1,  5'd0,  5'd4,  5'd3,  5'd0,  5'd0,  5'd14,
      5'd5,  5'd2,  5'd3,  5'd1,  5'd7,  5'd6,  5'd11, 5'd2,  5'd0,  5'd1,
      5'd4,  5'd8,  5'd6,  5'd9,  5'd13, 5'd3,
      5'd30, 5'd28, 5'd24, 5'd16, 5'd0,  5'd1,  5'd3,  5'd7,  5'd15, 5'd31,
      5'd4,  5'd27
   };
   localparam logic [3:0] ROM_LEN [ROM_SIZE] = '{
      4'd2, 4'd4, 4'd4, 4'd3, 4'd1, 4'd4, 4'd3, 4'd4, 4'd2, 4'd4,
      4'd3, 4'd4, 4'd2, 4'd2, 4'd3, 4'd4, 4'd4, 4'd3, 4'd3, 4'd1,
      4'd3, 4'd4, 4'd3, 4'd4, 4'd4, 4'd4,
      4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5,
      4'd5, 4'd5
   };
   localparam logic [7:0] ROM_CHAR [ROM_SIZE] = '{
      8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4A,
      8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54,
      8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A,
      8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
      8'h0A, 8'h08
   };

   // Finds the first table entry that matches a symbol of up to eight elements.
   function automatic lookup_type rom_lookup(input logic [7:0] bits, input logic [3:0] len);
      lookup_type r;
      r.hit  = 1'b0;
      r.code = ASCII_NONE;
      // Scan from the top so that the lowest matching entry wins.
      for (int e = ROM_SIZE - 1; e >= 0; e--) begin
         if (len == ROM_LEN[e] && bits == {3'b000, ROM_CODE[e]}) begin
            r.hit  = 1'b1;
            r.code = ROM_CHAR[e];
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/touch_morse_decoder_unit.sv =====
// Top level of the touch sensor Morse decoder.
`default_nettype none

// Takes one touch sample per transaction and can accept one every clock: the front
// classifies the sample against the threshold and queues it, the back updates the
// press and gap timers and loads at most one result (dot, dash, character, unknown
// code or word space) into the output register at the edge that pops its sample
// from the queue. The two-entry queue and the output register absorb stalls on the
// result channel, and input is stalled only when the queue fills.
module touch_morse_decoder_unit #(
   parameter int MAX_SYMBOLS = 6,
   parameter int COUNT_BITS  = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [15:0]                       req_touch_sample,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [2:0]                             rsp_result_kind,
   output logic [7:0]                             rsp_char_code,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [tmd_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [tmd_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [tmd_pkg::CSR_DATA_BITS-1:0]      prdata,
   output logic                                   pready
);

   logic             queue_full;
   logic             push;
   logic             push_pressed;
   logic             pop;
   logic             head_valid;
   logic             head_pressed;
   tmd_pkg::cfg_type cfg;

   // Register file and sample classification.
   tmd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_touch_sample (req_touch_sample),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready),
      .queue_full       (queue_full),
      .push             (push),
      .push_pressed     (push_pressed),
      .cfg              (cfg)
   );

   // Decoupling queue.
   tmd_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_pressed (push_pressed),
      .pop          (pop),
      .full         (queue_full),
      .head_valid   (head_valid),
      .head_pressed (head_pressed)
   );

   // Timing, decoding and result register.
   tmd_back #(
      .MAX_SYMBOLS (MAX_SYMBOLS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .head_valid      (head_valid),
      .head_pressed    (head_pressed),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_char_code   (rsp_char_code)
   );

endmodule

`default_nettype wire

// ===== rtl/tmd_front.sv =====
// Front part: register file and touch classification of incoming samples.
`default_nettype none

module tmd_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Sample channel
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [15:0]                          req_touch_sample,
   // Register port
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [tmd_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  wire logic [tmd_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic [tmd_pkg::CSR_DATA_BITS-1:0]         prdata,
   output logic                                      pready,
   // Toward the queue
   input  wire logic                                 queue_full,
   output logic                                      push,
   output logic                                      push_pressed,
   output tmd_pkg::cfg_type                          cfg
);

   logic [15:0] threshold_ff, threshold_in;
   logic [15:0] dash_ff, dash_in;
   logic [15:0] char_gap_ff, char_gap_in;
   logic [15:0] word_gap_ff, word_gap_in;
   logic        write_en;
   tmd_pkg::reg_index_type reg_index;

   assign pready    = 1'b1;
   assign write_en  = psel && penable && pwrite && pready;
   assign reg_index = tmd_pkg::reg_index_type'(paddr[3:2]);

   // Register write decode.
   always_comb begin
      threshold_in = threshold_ff;
      dash_in      = dash_ff;
      char_gap_in  = char_gap_ff;
      word_gap_in  = word_gap_ff;
      if (write_en) begin
         case (reg_index)
            tmd_pkg::REG_TOUCH_THRESHOLD: threshold_in = pwdata[15:0];
            tmd_pkg::REG_DASH_TICKS:      dash_in      = pwdata[15:0];
            tmd_pkg::REG_CHAR_GAP_TICKS:  char_gap_in  = pwdata[15:0];
            tmd_pkg::REG_WORD_GAP_TICKS:  word_gap_in  = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= tmd_pkg::THRESHOLD_RESET;
         dash_ff      <= tmd_pkg::DASH_RESET;
         char_gap_ff  <= tmd_pkg::CHAR_GAP_RESET;
         word_gap_ff  <= tmd_pkg::WORD_GAP_RESET;
      end else begin
         threshold_ff <= threshold_in;
         dash_ff      <= dash_in;
         char_gap_ff  <= char_gap_in;
         word_gap_ff  <= word_gap_in;
      end
   end

   // Register read mux.
   always_comb begin
      case (reg_index)
         tmd_pkg::REG_TOUCH_THRESHOLD: prdata = {16'h0000, threshold_ff};
         tmd_pkg::REG_DASH_TICKS:      prdata = {16'h0000, dash_ff};
         tmd_pkg::REG_CHAR_GAP_TICKS:  prdata = {16'h0000, char_gap_ff};
         tmd_pkg::REG_WORD_GAP_TICKS:  prdata = {16'h0000, word_gap_ff};
         default:                      prdata = '0;
      endcase
   end

   // A sample below the threshold is a touch; the transaction goes to the queue.
   assign req_stall    = queue_full;
   assign push         = req_valid && !queue_full;
   assign push_pressed = req_touch_sample < threshold_ff;

   assign cfg.dash_ticks     = dash_ff;
   assign cfg.char_gap_ticks = char_gap_ff;
   assign cfg.word_gap_ticks = word_gap_ff;

endmodule

`default_nettype wire

// ===== rtl/tmd_queue.sv =====
// Short queue of classified samples between the front and back parts.
`default_nettype none

module tmd_queue (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  wire logic push_pressed,
   input  wire logic pop,
   output logic      full,
   output logic      head_valid,
   output logic      head_pressed
);

   localparam int DEPTH   = tmd_pkg::QUEUE_DEPTH;
   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   logic [DEPTH-1:0]   entry_ff;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign full         = count_ff == COUNT_W'(DEPTH);
   assign head_valid   = count_ff != '0;
   assign head_pressed = entry_ff[rd_ptr_ff];
   assign do_push      = push && !full;
   assign do_pop       = pop && head_valid;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_pressed;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/tmd_back.sv =====
// Back part: press and gap timing, symbol assembly, lookup and result register.
`default_nettype none

module tmd_back #(
   parameter int MAX_SYMBOLS = 6,
   parameter int COUNT_BITS  = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire tmd_pkg::cfg_type cfg,
   input  wire logic             head_valid,
   input  wire logic             head_pressed,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [2:0]            rsp_result_kind,
   output logic [7:0]            rsp_char_code
);

   localparam int LEN_W = $clog2(MAX_SYMBOLS + 1);
   localparam int CMP_W = (COUNT_BITS > tmd_pkg::CFG_BITS) ? COUNT_BITS : tmd_pkg::CFG_BITS;

   logic                   press_active_ff, press_active_in;
   logic [COUNT_BITS-1:0]  press_ticks_ff, press_ticks_in;
   logic [COUNT_BITS-1:0]  idle_ticks_ff, idle_ticks_in;
   logic [MAX_SYMBOLS-1:0] symbol_bits_ff, symbol_bits_in;
   logic [LEN_W-1:0]       symbol_len_ff, symbol_len_in;
   logic                   space_armed_ff, space_armed_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   tmd_pkg::kind_type      kind_ff, kind_in;
   logic [7:0]             code_ff, code_in;

   logic                   can_load;
   logic                   has_result;
   tmd_pkg::kind_type      result_kind;
   logic [7:0]             result_code;
   logic                   is_dash;
   logic [COUNT_BITS-1:0]  idle_next;
   tmd_pkg::lookup_type    lookup;

   // The result register takes a new result when empty or being drained.
   assign can_load = !rsp_valid_ff || !rsp_stall;
   assign pop      = head_valid && can_load;

   assign is_dash   = CMP_W'(press_ticks_ff) >= CMP_W'(cfg.dash_ticks);
   assign idle_next = (idle_ticks_ff == '1) ? idle_ticks_ff : idle_ticks_ff + COUNT_BITS'(1);
   assign lookup    = tmd_pkg::rom_lookup(8'(symbol_bits_ff), 4'(symbol_len_ff));

   // State update for one popped transaction.
   always_comb begin
      press_active_in = press_active_ff;
      press_ticks_in  = press_ticks_ff;
      idle_ticks_in   = idle_ticks_ff;
      symbol_bits_in  = symbol_bits_ff;
      symbol_len_in   = symbol_len_ff;
      space_armed_in  = space_armed_ff;
      has_result      = 1'b0;
      result_kind     = tmd_pkg::KIND_DOT;
      result_code     = tmd_pkg::ASCII_NONE;
      if (pop) begin
         if (head_pressed) begin
            // Press in progress: count its length.
            press_active_in = 1'b1;
            if (!press_active_ff) begin
               press_ticks_in = COUNT_BITS'(1);
            end else if (press_ticks_ff != '1) begin
               press_ticks_in = press_ticks_ff + COUNT_BITS'(1);
            end
         end else if (press_active_ff) begin
            // Release: classify the press and store the element if room is left.
            press_active_in = 1'b0;
            press_ticks_in  = '0;
            idle_ticks_in   = '0;
            if (symbol_len_ff < LEN_W'(MAX_SYMBOLS)) begin
               symbol_bits_in = symbol_bits_ff |
                                (MAX_SYMBOLS'(is_dash) << symbol_len_ff);
               symbol_len_in  = symbol_len_ff + LEN_W'(1);
            end
            has_result  = 1'b1;
            result_kind = is_dash ? tmd_pkg::KIND_DASH : tmd_pkg::KIND_DOT;
         end else if (symbol_len_ff != '0 &&
                      CMP_W'(idle_next) > CMP_W'(cfg.char_gap_ticks)) begin
            // Character gap reached: decode the symbol.
            symbol_bits_in = '0;
            symbol_len_in  = '0;
            idle_ticks_in  = '0;
            has_result     = 1'b1;
            if (lookup.hit) begin
               space_armed_in = 1'b1;
               result_kind    = tmd_pkg::KIND_CHAR;
               result_code    = lookup.code;
            end else begin
               result_kind = tmd_pkg::KIND_UNKNOWN;
            end
         end else if (space_armed_ff &&
                      CMP_W'(idle_next) > CMP_W'(cfg.word_gap_ticks)) begin
            // Word gap after a character: one space, then disarm.
            space_armed_in = 1'b0;
            idle_ticks_in  = '0;
            has_result     = 1'b1;
            result_kind    = tmd_pkg::KIND_SPACE;
            result_code    = tmd_pkg::ASCII_SPACE;
         end else begin
            idle_ticks_in = idle_next;
         end
      end
   end

   // Result register next value.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      code_in      = code_ff;
      if (can_load) begin
         rsp_valid_in = has_result;
         if (has_result) begin
            kind_in = result_kind;
            code_in = result_code;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_active_ff <= 1'b0;
         press_ticks_ff  <= '0;
         idle_ticks_ff   <= '0;
         symbol_bits_ff  <= '0;
         symbol_len_ff   <= '0;
         space_armed_ff  <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         press_active_ff <= press_active_in;
         press_ticks_ff  <= press_ticks_in;
         idle_ticks_ff   <= idle_ticks_in;
         symbol_bits_ff  <= symbol_bits_in;
         symbol_len_ff   <= symbol_len_in;
         space_armed_ff  <= space_armed_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      code_ff <= code_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = 3'(kind_ff);
   assign rsp_char_code   = code_ff;

   // The symbol never holds more elements than it has room for.
   assert property (@(posedge clock) disable iff (reset)
      symbol_len_ff <= LEN_W'(MAX_SYMBOLS))
      else $error("symbol length beyond its capacity");

   // A press in progress has counted at least one tick.
   assert property (@(posedge clock) disable iff (reset)
      press_active_ff |-> press_ticks_ff != '0)
      else $error("active press with zero length");

   // Nothing leaves the queue while a result waits on a stalled output.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !pop)
      else $error("transaction popped while output is stalled");

   // A release always produces an element result and restarts the gap timer.
   assert property (@(posedge clock) disable iff (reset)
      (pop && !head_pressed && press_active_ff) |=> (rsp_valid_ff && idle_ticks_ff == '0))
      else $error("release did not produce an element");

endmodule

`default_nettype wire
